>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/psw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg
// Types, codes and helpers of the packet sequence window checker.
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int SEQ_W   = 7;
    localparam int LEN_W   = 13;
    localparam int CH_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACILITY    = 1'd1;

    localparam logic [SEQ_W-1:0] WINDOW_RESET   = 7'd2;
    localparam logic [LEN_W-1:0] FACILITY_RESET = 13'd128;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_RR    = 2'd1,
        OP_RNR   = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        DIAG_OK          = 4'd0,
        DIAG_PS_RANGE    = 4'd1,
        DIAG_PR_RANGE    = 4'd2,
        DIAG_EMPTY       = 4'd3,
        DIAG_TOO_LONG    = 4'd4,
        DIAG_OVER_FAC    = 4'd5,
        DIAG_OUT_OF_ORDER = 4'd6,
        DIAG_PS_WINDOW   = 4'd7,
        DIAG_BAD_PR      = 4'd8
    } t_diag;

    typedef struct packed {
        t_op              op;
        logic             in_range;
        logic             from_callee;
        logic [7:0]       send_seq;
        logic [7:0]       recv_seq;
        logic [LEN_W-1:0] data_length;
    } t_item;

    typedef struct packed {
        logic [SEQ_W-1:0] caller_send_seq;
        logic [SEQ_W-1:0] caller_recv_low;
        logic [SEQ_W-1:0] callee_send_seq;
        logic [SEQ_W-1:0] callee_recv_low;
    } t_flow;

    typedef struct packed {
        logic  forwarded;
        t_diag diag;
    } t_result;

    typedef logic [SEQ_W-1:0] t_seq_tab [1 << SEQ_W];

    // inclusive modular range, wraps when hi is below lo
    function automatic logic seq_in_range(input logic [SEQ_W-1:0] x,
                                          input logic [SEQ_W-1:0] lo,
                                          input logic [SEQ_W-1:0] hi);
        logic r;
        if (hi < lo) begin
            r = (x <= hi) || (x >= lo);
        end else if (hi > lo) begin
            r = (x >= lo) && (x <= hi);
        end else begin
            r = (x == lo);
        end
        return r;
    endfunction

endpackage

>>> src/psw_flow_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_flow_table
// Per-channel flow state memory with valid bits and write-to-read bypass.
// ----------------------------------------------------------------------------
module psw_flow_table #(
    parameter int CHANNELS = 16,
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  psw_pkg::t_flow  i_wr_data,
    output psw_pkg::t_flow  o_rd_data
);

    psw_pkg::t_flow r_mem [CHANNELS];
    psw_pkg::t_flow r_rd_data;
    psw_pkg::t_flow r_byp_data;
    logic [CHANNELS-1:0] r_valid;
    logic r_rd_valid;
    logic r_byp_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_byp_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                // write landing in the same edge as the read
                r_byp_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= i_wr_data;
        end
    end

    always_comb begin
        if (r_byp_hit) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_valid) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

>>> src/psw_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_check
// Sequence, length and window checks of one item against its channel state.
// ----------------------------------------------------------------------------
module psw_check #(
    parameter int SEQ_MODULUS    = 128,
    parameter int MAX_DATA_BYTES = 4096
) (
    input  psw_pkg::t_item                 i_item,
    input  psw_pkg::t_flow                 i_entry,
    input  logic [psw_pkg::SEQ_W-1:0]      i_win_mod,
    input  logic [psw_pkg::LEN_W-1:0]      i_facility,
    output psw_pkg::t_result               o_result,
    output logic                           o_wr_en,
    output psw_pkg::t_flow                 o_entry
);

    localparam logic [7:0] MOD8 = 8'(SEQ_MODULUS);
    localparam logic [psw_pkg::SEQ_W-1:0] SEQ_LAST = psw_pkg::SEQ_W'(SEQ_MODULUS - 1);
    localparam logic [psw_pkg::LEN_W-1:0] MAX_LEN = psw_pkg::LEN_W'(MAX_DATA_BYTES);

    logic [psw_pkg::SEQ_W-1:0] own_ps, own_pr, peer_ps, peer_pr;
    logic [psw_pkg::SEQ_W-1:0] ps, pr, ps_next, win_hi;
    logic [7:0] win_sum;
    logic ps_big, pr_big;
    logic ok;
    psw_pkg::t_diag diag;
    psw_pkg::t_flow upd;

    assign own_ps  = i_item.from_callee ? i_entry.callee_send_seq : i_entry.caller_send_seq;
    assign own_pr  = i_item.from_callee ? i_entry.callee_recv_low : i_entry.caller_recv_low;
    assign peer_ps = i_item.from_callee ? i_entry.caller_send_seq : i_entry.callee_send_seq;
    assign peer_pr = i_item.from_callee ? i_entry.caller_recv_low : i_entry.callee_recv_low;

    assign ps     = i_item.send_seq[psw_pkg::SEQ_W-1:0];
    assign pr     = i_item.recv_seq[psw_pkg::SEQ_W-1:0];
    assign ps_big = i_item.send_seq >= MOD8;
    assign pr_big = i_item.recv_seq >= MOD8;

    // window top, both terms below the modulus so one subtract wraps it
    assign win_sum = {1'b0, peer_pr} + {1'b0, i_win_mod};
    assign win_hi  = (win_sum >= MOD8) ? psw_pkg::SEQ_W'(win_sum - MOD8)
                                       : win_sum[psw_pkg::SEQ_W-1:0];
    assign ps_next = (ps == SEQ_LAST) ? '0 : ps + 1'b1;

    always_comb begin
        diag = psw_pkg::DIAG_OK;
        ok   = 1'b0;
        upd  = i_entry;
        case (i_item.op)
            psw_pkg::OP_RESET: begin
                ok  = 1'b1;
                upd = '0;
            end
            psw_pkg::OP_DATA: begin
                if (ps_big) begin
                    diag = psw_pkg::DIAG_PS_RANGE;
                end else if (pr_big) begin
                    diag = psw_pkg::DIAG_PR_RANGE;
                end else if (i_item.data_length == '0) begin
                    diag = psw_pkg::DIAG_EMPTY;
                end else if (i_item.data_length > MAX_LEN) begin
                    diag = psw_pkg::DIAG_TOO_LONG;
                end else if (i_item.data_length > i_facility) begin
                    diag = psw_pkg::DIAG_OVER_FAC;
                end else if (ps != own_ps) begin
                    diag = psw_pkg::DIAG_OUT_OF_ORDER;
                end else if (!psw_pkg::seq_in_range(ps, peer_pr, win_hi)) begin
                    diag = psw_pkg::DIAG_PS_WINDOW;
                end else if (!psw_pkg::seq_in_range(pr, own_pr, peer_ps)) begin
                    diag = psw_pkg::DIAG_BAD_PR;
                end else begin
                    ok = 1'b1;
                    if (i_item.from_callee) begin
                        upd.callee_send_seq = ps_next;
                        upd.callee_recv_low = pr;
                    end else begin
                        upd.caller_send_seq = ps_next;
                        upd.caller_recv_low = pr;
                    end
                end
            end
            default: begin
                // receive ready and receive not ready
                if (pr_big) begin
                    diag = psw_pkg::DIAG_PR_RANGE;
                end else if (!psw_pkg::seq_in_range(pr, own_pr, peer_ps)) begin
                    diag = psw_pkg::DIAG_BAD_PR;
                end else begin
                    ok = 1'b1;
                    if (i_item.from_callee) begin
                        upd.callee_recv_low = pr;
                    end else begin
                        upd.caller_recv_low = pr;
                    end
                end
            end
        endcase
    end

    // unknown channels are not forwarded and carry no diagnostic
    always_comb begin
        if (i_item.in_range) begin
            o_result.forwarded = ok;
            o_result.diag      = diag;
        end else begin
            o_result.forwarded = 1'b0;
            o_result.diag      = psw_pkg::DIAG_OK;
        end
    end

    assign o_wr_en = i_item.in_range && ok;
    assign o_entry = upd;

endmodule

>>> src/packet_sequence_window_checker_unit.sv
`timescale 1ns / 1ps
// pipeline: an input transfer loads the s1 item register and reads the flow table; the check
// result is registered into the output register when s1 fires, and an output stall holds both
// throughput: one item per cycle while results are taken; flow table read at the input transfer,
// written when the item leaves s1; a write to the channel being read is bypassed into that read
// reset: synchronous active low; clears flow table valid bits (all channels read as zero),
// empties the pipeline, window size back to 2 and facility to 128 bytes
// ----------------------------------------------------------------------------
// packet_sequence_window_checker_unit
// Per-channel sliding window flow control check for data, window update and flow reset packets.
// ----------------------------------------------------------------------------
module packet_sequence_window_checker_unit #(
    parameter int CHANNELS       = 16,
    parameter int SEQ_MODULUS    = 128,
    parameter int MAX_DATA_BYTES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_op,
    input  logic [psw_pkg::CH_W-1:0]          i_channel,
    input  logic                              i_from_callee,
    input  logic [7:0]                        i_send_seq,
    input  logic [7:0]                        i_recv_seq,
    input  logic [psw_pkg::LEN_W-1:0]         i_data_length,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_forwarded,
    output logic [3:0]                        o_diag_code,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [psw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [psw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = (AW > psw_pkg::CH_W) ? AW : psw_pkg::CH_W;

    function automatic psw_pkg::t_seq_tab build_win_mod();
        psw_pkg::t_seq_tab tab;
        for (int i = 0; i < (1 << psw_pkg::SEQ_W); i++) begin
            tab[i] = psw_pkg::SEQ_W'(i % SEQ_MODULUS);
        end
        return tab;
    endfunction

    localparam psw_pkg::t_seq_tab WIN_MOD = build_win_mod();

    logic                          r_s1_valid;
    psw_pkg::t_item                r_s1_item;
    logic [AW-1:0]                 r_s1_addr;
    logic                          r_out_valid;
    psw_pkg::t_result              r_out;
    logic [psw_pkg::SEQ_W-1:0]     r_win_mod;
    logic [psw_pkg::LEN_W-1:0]     r_facility;

    logic                          in_xfer;
    logic                          s1_fire;
    logic [XW-1:0]                 ch_ext;
    logic [AW-1:0]                 rd_addr;
    psw_pkg::t_item                n_item;
    psw_pkg::t_flow                entry;
    psw_pkg::t_flow                wr_entry;
    psw_pkg::t_result              n_out;
    logic                          chk_wr;

    assign s1_fire = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign in_xfer = i_valid && o_ready;

    assign ch_ext  = XW'(i_channel);
    assign rd_addr = ch_ext[AW-1:0];

    always_comb begin
        n_item.op          = psw_pkg::t_op'(i_op);
        n_item.in_range    = 32'(i_channel) < CHANNELS;
        n_item.from_callee = i_from_callee;
        n_item.send_seq    = i_send_seq;
        n_item.recv_seq    = i_recv_seq;
        n_item.data_length = i_data_length;
    end

    psw_flow_table #(
        .CHANNELS (CHANNELS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (rd_addr),
        .i_wr_en   (s1_fire && chk_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_entry),
        .o_rd_data (entry)
    );

    psw_check #(
        .SEQ_MODULUS    (SEQ_MODULUS),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_check (
        .i_item     (r_s1_item),
        .i_entry    (entry),
        .i_win_mod  (r_win_mod),
        .i_facility (r_facility),
        .o_result   (n_out),
        .o_wr_en    (chk_wr),
        .o_entry    (wr_entry)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= n_item;
            r_s1_addr <= rd_addr;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    // configuration, window kept already reduced by the modulus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_mod  <= WIN_MOD[psw_pkg::WINDOW_RESET];
            r_facility <= psw_pkg::FACILITY_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == psw_pkg::CFG_WINDOW_SIZE) begin
                r_win_mod <= WIN_MOD[i_cfg_data[psw_pkg::SEQ_W-1:0]];
            end else begin
                r_facility <= i_cfg_data[psw_pkg::LEN_W-1:0];
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_forwarded = r_out.forwarded;
    assign o_diag_code = r_out.diag;

endmodule

>>> src/psw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_checker
// Port-level checks of the window checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_forwarded,
    input logic [3:0] o_diag_code
);

    // a forwarded item never carries a diagnostic
    `ASSERT_IMPLY(a_fwd_clean, i_clk, i_rst_n, o_valid && o_forwarded, o_diag_code == psw_pkg::DIAG_OK, "forwarded result with nonzero diagnostic")

    // input stalls only behind a stalled result
    `ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "input stalled without output backpressure")

    // a transfer in shows up as a result once it has passed stage s1, unless already backed up
    `ASSERT_NEXT(a_latency, i_clk, i_rst_n, i_valid && o_ready, ##1 o_valid, "accepted item produced no result in time")

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_forwarded) && $stable(o_diag_code), "stalled result changed")

endmodule

bind packet_sequence_window_checker_unit psw_checker u_psw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_forwarded (o_forwarded),
    .o_diag_code (o_diag_code)
);

>>> verif/packet_sequence_window_checker_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_sequence_window_checker_unit_test
// Drives data, window update and flow reset packets into the sequence window
// checker, predicts forward and diagnostic for each transfer from a private
// copy of the per-channel flow table, and compares every result in order.
// ----------------------------------------------------------------------------
module packet_sequence_window_checker_unit_test;

    localparam int NUM_CHAN      = 16;
    localparam int MAX_BYTES     = 4096;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        psw_pkg::t_op                op;
        logic [psw_pkg::CH_W-1:0]    channel;
        logic                        callee;
        logic [7:0]                  send_seq;
        logic [7:0]                  recv_seq;
        logic [psw_pkg::LEN_W-1:0]   data_length;
    } t_packet;

    class flow_window_scoreboard;
        logic [psw_pkg::SEQ_W-1:0] caller_send_seq [NUM_CHAN];
        logic [psw_pkg::SEQ_W-1:0] caller_recv_low [NUM_CHAN];
        logic [psw_pkg::SEQ_W-1:0] callee_send_seq [NUM_CHAN];
        logic [psw_pkg::SEQ_W-1:0] callee_recv_low [NUM_CHAN];
        logic [psw_pkg::SEQ_W-1:0] window_size;
        logic [psw_pkg::LEN_W-1:0] facility_bytes;
        psw_pkg::t_result          expected_results [$];
        int                        mismatches;

        function new();
            window_size    = psw_pkg::WINDOW_RESET;
            facility_bytes = psw_pkg::FACILITY_RESET;
            mismatches     = 0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                caller_send_seq[i] = '0;
                caller_recv_low[i] = '0;
                callee_send_seq[i] = '0;
                callee_recv_low[i] = '0;
            end
        endfunction

        function void write_reg(logic [psw_pkg::CFG_IDX_W-1:0] idx,
                                logic [psw_pkg::CFG_DATA_W-1:0] data);
            if (idx == psw_pkg::CFG_WINDOW_SIZE) begin
                window_size = data[psw_pkg::SEQ_W-1:0];
            end else begin
                facility_bytes = data[psw_pkg::LEN_W-1:0];
            end
        endfunction

        // distance from lo, taken mod the sequence range, covers wrapped windows too
        function bit wrap_contains(logic [psw_pkg::SEQ_W-1:0] x,
                                   logic [psw_pkg::SEQ_W-1:0] lo,
                                   logic [psw_pkg::SEQ_W-1:0] hi);
            logic [psw_pkg::SEQ_W-1:0] dx;
            logic [psw_pkg::SEQ_W-1:0] dh;
            dx = x - lo;
            dh = hi - lo;
            return dx <= dh;
        endfunction

        function void note_item(t_packet p);
            logic [psw_pkg::SEQ_W-1:0] own_ps;
            logic [psw_pkg::SEQ_W-1:0] own_pr;
            logic [psw_pkg::SEQ_W-1:0] peer_ps;
            logic [psw_pkg::SEQ_W-1:0] peer_pr;
            logic [psw_pkg::SEQ_W-1:0] win_hi;
            psw_pkg::t_result          r;
            own_ps  = p.callee ? callee_send_seq[p.channel] : caller_send_seq[p.channel];
            own_pr  = p.callee ? callee_recv_low[p.channel] : caller_recv_low[p.channel];
            peer_ps = p.callee ? caller_send_seq[p.channel] : callee_send_seq[p.channel];
            peer_pr = p.callee ? caller_recv_low[p.channel] : callee_recv_low[p.channel];
            win_hi  = peer_pr + window_size;
            r.forwarded = 1'b0;
            r.diag      = psw_pkg::DIAG_OK;
            if (p.op == psw_pkg::OP_RESET) begin
                own_ps = '0;
                own_pr = '0;
                caller_send_seq[p.channel] = '0;
                caller_recv_low[p.channel] = '0;
                callee_send_seq[p.channel] = '0;
                callee_recv_low[p.channel] = '0;
                r.forwarded = 1'b1;
            end else if (p.op == psw_pkg::OP_DATA) begin
                if (p.send_seq[7]) begin
                    r.diag = psw_pkg::DIAG_PS_RANGE;
                end else if (p.recv_seq[7]) begin
                    r.diag = psw_pkg::DIAG_PR_RANGE;
                end else if (p.data_length == 0) begin
                    r.diag = psw_pkg::DIAG_EMPTY;
                end else if (p.data_length > MAX_BYTES) begin
                    r.diag = psw_pkg::DIAG_TOO_LONG;
                end else if (p.data_length > facility_bytes) begin
                    r.diag = psw_pkg::DIAG_OVER_FAC;
                end else if (p.send_seq[psw_pkg::SEQ_W-1:0] != own_ps) begin
                    r.diag = psw_pkg::DIAG_OUT_OF_ORDER;
                end else if (!wrap_contains(p.send_seq[psw_pkg::SEQ_W-1:0], peer_pr,
                                            win_hi)) begin
                    r.diag = psw_pkg::DIAG_PS_WINDOW;
                end else if (!wrap_contains(p.recv_seq[psw_pkg::SEQ_W-1:0], own_pr,
                                            peer_ps)) begin
                    r.diag = psw_pkg::DIAG_BAD_PR;
                end else begin
                    own_ps      = p.send_seq[psw_pkg::SEQ_W-1:0] + 1'b1;
                    own_pr      = p.recv_seq[psw_pkg::SEQ_W-1:0];
                    r.forwarded = 1'b1;
                end
            end else begin
                if (p.recv_seq[7]) begin
                    r.diag = psw_pkg::DIAG_PR_RANGE;
                end else if (!wrap_contains(p.recv_seq[psw_pkg::SEQ_W-1:0], own_pr,
                                            peer_ps)) begin
                    r.diag = psw_pkg::DIAG_BAD_PR;
                end else begin
                    own_pr      = p.recv_seq[psw_pkg::SEQ_W-1:0];
                    r.forwarded = 1'b1;
                end
            end
            if (p.callee) begin
                callee_send_seq[p.channel] = own_ps;
                callee_recv_low[p.channel] = own_pr;
            end else begin
                caller_send_seq[p.channel] = own_ps;
                caller_recv_low[p.channel] = own_pr;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic fwd, logic [3:0] diag);
            psw_pkg::t_result e;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result forwarded %0b diag %0d",
                         $time, fwd, diag);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (fwd !== e.forwarded) begin
                $display("%0t: forwarded mismatch: expected %0b, actual %0b",
                         $time, e.forwarded, fwd);
                mismatches++;
            end
            if (diag !== e.diag) begin
                $display("%0t: diag_code mismatch: expected %0d, actual %0d",
                         $time, e.diag, diag);
                mismatches++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic [1:0]                       i_op;
    logic [psw_pkg::CH_W-1:0]         i_channel;
    logic                             i_from_callee;
    logic [7:0]                       i_send_seq;
    logic [7:0]                       i_recv_seq;
    logic [psw_pkg::LEN_W-1:0]        i_data_length;
    logic                             o_valid;
    logic                             i_ready;
    logic                             o_forwarded;
    logic [3:0]                       o_diag_code;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [psw_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [psw_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    flow_window_scoreboard flow_sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    packet_sequence_window_checker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_channel     (i_channel),
        .i_from_callee (i_from_callee),
        .i_send_seq    (i_send_seq),
        .i_recv_seq    (i_recv_seq),
        .i_data_length (i_data_length),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_forwarded   (o_forwarded),
        .o_diag_code   (o_diag_code),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            flow_sb.check_result(o_forwarded, o_diag_code);
        end
    end

    // counts cycles with no transfer on the input, output or configuration port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_packet(input t_packet p);
        i_valid       <= 1'b1;
        i_op          <= p.op;
        i_channel     <= p.channel;
        i_from_callee <= p.callee;
        i_send_seq    <= p.send_seq;
        i_recv_seq    <= p.recv_seq;
        i_data_length <= p.data_length;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        flow_sb.note_item(p);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic directed_packet(input psw_pkg::t_op op,
                                   input logic [psw_pkg::CH_W-1:0] ch,
                                   input logic callee, input logic [7:0] ps,
                                   input logic [7:0] pr,
                                   input logic [psw_pkg::LEN_W-1:0] len);
        t_packet p;
        p.op          = op;
        p.channel     = ch;
        p.callee      = callee;
        p.send_seq    = ps;
        p.recv_seq    = pr;
        p.data_length = len;
        send_packet(p);
    endtask

    // mostly in-order traffic built from the predicted flow table, some noise
    task automatic build_packet(output t_packet p);
        int                        roll;
        int                        kind;
        int                        len_cap;
        logic [psw_pkg::SEQ_W-1:0] own_ps;
        logic [psw_pkg::SEQ_W-1:0] own_pr;
        logic [psw_pkg::SEQ_W-1:0] peer_ps;
        logic [psw_pkg::SEQ_W-1:0] span;
        logic [psw_pkg::SEQ_W-1:0] pick;
        p.channel = psw_pkg::CH_W'(($urandom_range(0, 99) < 80)
                                   ? $urandom_range(0, 3)
                                   : $urandom_range(0, NUM_CHAN - 1));
        p.callee  = 1'($urandom_range(0, 1));
        roll      = $urandom_range(0, 99);
        if (roll < 10) begin
            p.op          = psw_pkg::t_op'($urandom_range(0, 3));
            p.send_seq    = 8'($urandom_range(0, 255));
            p.recv_seq    = 8'($urandom_range(0, 255));
            p.data_length = psw_pkg::LEN_W'($urandom_range(0, (1 << psw_pkg::LEN_W) - 1));
            return;
        end
        own_ps  = p.callee ? flow_sb.callee_send_seq[p.channel]
                           : flow_sb.caller_send_seq[p.channel];
        own_pr  = p.callee ? flow_sb.callee_recv_low[p.channel]
                           : flow_sb.caller_recv_low[p.channel];
        peer_ps = p.callee ? flow_sb.caller_send_seq[p.channel]
                           : flow_sb.callee_send_seq[p.channel];
        span    = peer_ps - own_pr;
        // lean on the top of the range so the peer window keeps opening
        pick    = $urandom_range(0, 1) ? span : psw_pkg::SEQ_W'($urandom_range(0, span));
        kind    = $urandom_range(0, 99);
        if (kind < 2) begin
            p.op = psw_pkg::OP_RESET;
        end else if (kind < 62) begin
            p.op = psw_pkg::OP_DATA;
        end else if (kind < 81) begin
            p.op = psw_pkg::OP_RR;
        end else begin
            p.op = psw_pkg::OP_RNR;
        end
        len_cap       = (flow_sb.facility_bytes > MAX_BYTES) ? MAX_BYTES
                                                             : flow_sb.facility_bytes;
        if (len_cap < 1) begin
            len_cap = 1;
        end
        p.send_seq    = {1'b0, own_ps};
        p.recv_seq    = {1'b0, own_pr + pick};
        p.data_length = psw_pkg::LEN_W'(($urandom_range(0, 3) == 0)
                                        ? len_cap : $urandom_range(1, len_cap));
        if (roll < 25) begin
            case ($urandom_range(0, 3))
                0: p.send_seq    = 8'($urandom_range(0, 255));
                1: p.recv_seq    = 8'($urandom_range(0, 255));
                2: p.data_length = psw_pkg::LEN_W'($urandom_range(0,
                                       (1 << psw_pkg::LEN_W) - 1));
                default: p.op    = psw_pkg::t_op'($urandom_range(0, 3));
            endcase
        end
    endtask

    task automatic write_register(input logic [psw_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [psw_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        flow_sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the sender until every expected result has come back
    task automatic settle_results();
        i_valid <= 1'b0;
        while (flow_sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [psw_pkg::CFG_DATA_W-1:0] win,
                             input logic [psw_pkg::CFG_DATA_W-1:0] fac,
                             input int sender_pct, input int receiver_pct,
                             input int count, input bit mid_pause);
        t_packet p;
        settle_results();
        write_register(psw_pkg::CFG_WINDOW_SIZE, win);
        write_register(psw_pkg::CFG_FACILITY, fac);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        for (int n = 0; n < count; n++) begin
            if (mid_pause && n == count / 2) begin
                settle_results();
            end
            build_packet(p);
            send_packet(p);
        end
    endtask

    initial begin
        t_packet p;
        flow_sb        = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_op          <= psw_pkg::OP_DATA;
        i_channel     <= '0;
        i_from_callee <= 1'b0;
        i_send_seq    <= '0;
        i_recv_seq    <= '0;
        i_data_length <= '0;
        i_ready       <= 1'b1;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= psw_pkg::CFG_WINDOW_SIZE;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default window 2, facility 128
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd0,   8'd0,   13'd1);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd255, 8'd0,   13'd1);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd1,   8'd128, 13'd1);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd1,   8'd0,   13'd0);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd1,   8'd0,   13'd8191);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd1,   8'd0,   13'd4097);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd1,   8'd0,   13'd4096);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd1,   8'd0,   13'd129);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd5,   8'd0,   13'd1);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd1,   8'd0,   13'd128);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd2,   8'd0,   13'd1);
        // window of two is used up
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd3,   8'd0,   13'd1);
        directed_packet(psw_pkg::OP_RR,    4'd0,  1'b1, 8'd0,   8'd3,   13'd0);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b0, 8'd3,   8'd1,   13'd1);
        directed_packet(psw_pkg::OP_RNR,   4'd0,  1'b0, 8'd0,   8'd200, 13'd0);
        directed_packet(psw_pkg::OP_RNR,   4'd0,  1'b0, 8'd0,   8'd0,   13'd0);
        directed_packet(psw_pkg::OP_DATA,  4'd0,  1'b1, 8'd0,   8'd3,   13'd10);
        directed_packet(psw_pkg::OP_RR,    4'd0,  1'b1, 8'd0,   8'd255, 13'd0);
        directed_packet(psw_pkg::OP_RESET, 4'd0,  1'b0, 8'd0,   8'd0,   13'd0);
        directed_packet(psw_pkg::OP_RESET, 4'd15, 1'b1, 8'd255, 8'd255, 13'd8191);
        // single-point receive range after reset
        directed_packet(psw_pkg::OP_DATA,  4'd15, 1'b1, 8'd0,   8'd127, 13'd1);
        directed_packet(psw_pkg::OP_RR,    4'd15, 1'b0, 8'd0,   8'd0,   13'd0);
        directed_packet(psw_pkg::OP_DATA,  4'd15, 1'b0, 8'd127, 8'd0,   13'd1);
        directed_packet(psw_pkg::OP_RNR,   4'd15, 1'b1, 8'd0,   8'd1,   13'd0);

        send_idle_pct = 0;
        for (int n = 0; n < 100; n++) begin
            build_packet(p);
            send_packet(p);
        end

        run_phase(13'd127,    13'd4096, 45, 0,  200, 1'b1);
        run_phase(13'd0,      13'd1,    0,  45, 150, 1'b0);
        // upper bits of the window write are dropped, leaving 5
        run_phase(13'h1F85,   13'd8191, 34, 34, 200, 1'b0);
        run_phase(13'd1,      13'd0,    0,  0,  60,  1'b0);
        run_phase(13'd63,     13'd512,  34, 34, 100, 1'b0);

        settle_results();
        if (flow_sb.expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time,
                     flow_sb.expected_results.size());
            flow_sb.mismatches++;
        end
        if (flow_sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
